[rtl/core/bfwd_pkg.sv]
package bfwd_pkg;

  localparam int MAC_W = 48;
  localparam int STAMP_W = 32;

  localparam logic [MAC_W-1:0] BPDU_ADDR = 48'h0180_c200_0000;

  localparam logic [2:0] ST_DISABLED   = 3'd0;
  localparam logic [2:0] ST_BLOCKING   = 3'd1;
  localparam logic [2:0] ST_LISTENING  = 3'd2;
  localparam logic [2:0] ST_LEARNING   = 3'd3;
  localparam logic [2:0] ST_FORWARDING = 3'd4;

  localparam logic [1:0] REG_AGING_TIME  = 2'd0;
  localparam logic [1:0] REG_PORTS_IN_USE = 2'd1;
  localparam logic [1:0] REG_PORT_STATES = 2'd2;

  localparam logic [31:0] AGING_TIME_RST   = 32'd300;
  localparam logic [3:0]  PORTS_IN_USE_RST = 4'd1;
  localparam logic [23:0] PORT_STATES_RST  = 24'd9586980;

  typedef enum logic [3:0] {
    DISP_PORT_ZERO   = 4'd0,
    DISP_DISABLED_UP = 4'd1,
    DISP_BPDU        = 4'd2,
    DISP_BLOCKED     = 4'd3,
    DISP_FLOOD_GROUP = 4'd4,
    DISP_FLOOD_UNK   = 4'd5,
    DISP_FORWARD     = 4'd6,
    DISP_FLOOD_AGED  = 4'd7,
    DISP_SAME_PORT   = 4'd8,
    DISP_SAME_AGED   = 4'd9,
    DISP_BAD_STATE   = 4'd10
  } disp_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_SCAN_LAST,
    B_LEARN,
    B_PICK,
    B_DECIDE,
    B_INVAL,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [31:0] aging_time;
    logic [3:0]  ports_in_use;
    logic [23:0] port_states;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         port;
    logic [MAC_W-1:0]   dst;
    logic [MAC_W-1:0]   src;
    logic [STAMP_W-1:0] now;
    logic               final_res;
    disp_t              disp;
    logic [7:0]         mask;
    logic               consumed;
  } job_t;

  typedef struct packed {
    logic               used;
    logic               valid;
    logic [MAC_W-1:0]   mac;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

  function automatic logic [2:0] port_state(logic [23:0] states, logic [2:0] p,
                                            int num_ports);
    if (int'(p) >= num_ports) return ST_DISABLED;
    return states[int'(p)*3 +: 3];
  endfunction

  function automatic logic [3:0] port_limit(logic [3:0] piu, int num_ports);
    logic [3:0] lim;
    lim = piu;
    if (int'(lim) > num_ports) lim = 4'(num_ports);
    if (lim > 4'd8) lim = 4'd8;
    return lim;
  endfunction

  function automatic logic [7:0] flood_mask(cfg_t cfg, logic [2:0] ingress,
                                            int num_ports);
    logic [7:0] m;
    logic [3:0] lim;
    m = '0;
    lim = port_limit(cfg.ports_in_use, num_ports);
    for (int i = 1; i < 8; i++) begin
      if (4'(i) < lim && 3'(i) != ingress &&
          port_state(cfg.port_states, 3'(i), num_ports) == ST_FORWARDING)
        m[i] = 1'b1;
    end
    return m;
  endfunction

endpackage

[rtl/core/bfwd_frame_if.sv]
interface bfwd_frame_if;
  logic        valid;
  logic        ready;
  logic [2:0]  ingress_port;
  logic [47:0] dest_mac;
  logic [47:0] source_mac;
  logic [31:0] now;

  modport source (output valid, ingress_port, dest_mac, source_mac, now, input ready);
  modport sink (input valid, ingress_port, dest_mac, source_mac, now, output ready);
endinterface

[rtl/core/bfwd_result_if.sv]
interface bfwd_result_if;
  logic       valid;
  logic       ready;
  logic [3:0] disposition;
  logic [7:0] egress_mask;
  logic       consumed;
  logic       learn_no_space;

  modport source (output valid, disposition, egress_mask, consumed, learn_no_space,
                  input ready);
  modport sink (input valid, disposition, egress_mask, consumed, learn_no_space,
                output ready);
endinterface

[rtl/core/learning_bridge_forwarder.sv]
// Frames settled by port state or group destination go from the queue straight to
// the result register; table frames pass first through the scan, learn, pick,
// decide and invalidate states. The back end takes one frame at a time and holds
// a table frame for the single scan that reads every port bank in parallel through
// one read port each; the queue takes frames meanwhile. Reset: synchronous; then a
// clearing pass of all entries takes no frames; config writes are taken throughout.
module learning_bridge_forwarder #(
  parameter int NUM_PORTS = 8,
  parameter int ENTRIES_PER_PORT = 256
) (
  input  logic         clk,
  input  logic         rst,
  bfwd_frame_if.sink   frame,
  bfwd_result_if.source result,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import bfwd_pkg::*;

  cfg_t cfg;
  logic q_full, clearing, push, pop, job_valid;
  job_t push_job, job;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.aging_time <= AGING_TIME_RST;
      cfg.ports_in_use <= PORTS_IN_USE_RST;
      cfg.port_states <= PORT_STATES_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_AGING_TIME: cfg.aging_time <= pwdata;
        REG_PORTS_IN_USE: cfg.ports_in_use <= pwdata[3:0];
        REG_PORT_STATES: cfg.port_states <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_AGING_TIME: prdata = cfg.aging_time;
      REG_PORTS_IN_USE: prdata = {28'd0, cfg.ports_in_use};
      REG_PORT_STATES: prdata = {8'd0, cfg.port_states};
      default: prdata = '0;
    endcase
  end

  bfwd_front #(.NUM_PORTS(NUM_PORTS)) u_front (
    .frame(frame), .cfg(cfg), .q_full(q_full), .clearing(clearing),
    .push(push), .job(push_job)
  );

  bfwd_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_job(push_job), .pop(pop),
    .full(q_full), .job_valid(job_valid), .job(job)
  );

  bfwd_back #(.NUM_PORTS(NUM_PORTS), .ENTRIES_PER_PORT(ENTRIES_PER_PORT)) u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .job_valid(job_valid), .job(job),
    .pop(pop), .clearing(clearing), .result(result)
  );
endmodule

[rtl/core/bfwd_front.sv]
module bfwd_front #(
  parameter int NUM_PORTS = 8
) (
  bfwd_frame_if.sink     frame,
  input  bfwd_pkg::cfg_t cfg,
  input  logic           q_full,
  input  logic           clearing,
  output logic           push,
  output bfwd_pkg::job_t job
);
  import bfwd_pkg::*;

  logic [2:0] st;

  assign frame.ready = !q_full && !clearing;
  assign push = frame.valid && frame.ready;
  assign st = port_state(cfg.port_states, frame.ingress_port, NUM_PORTS);

  always_comb begin
    job.port = frame.ingress_port;
    job.dst = frame.dest_mac;
    job.src = frame.source_mac;
    job.now = frame.now;
    job.final_res = 1'b1;
    job.disp = DISP_PORT_ZERO;
    job.mask = '0;
    job.consumed = 1'b0;
    if (frame.ingress_port == 3'd0) begin
      job.disp = DISP_PORT_ZERO;
    end else if (st == ST_DISABLED) begin
      job.disp = DISP_DISABLED_UP;
    end else if (frame.dest_mac == BPDU_ADDR) begin
      job.disp = DISP_BPDU;
      job.consumed = 1'b1;
    end else if (st == ST_BLOCKING || st == ST_LISTENING || st == ST_LEARNING) begin
      job.disp = DISP_BLOCKED;
    end else if (st != ST_FORWARDING) begin
      job.disp = DISP_BAD_STATE;
    end else if (frame.dest_mac[40]) begin
      job.disp = DISP_FLOOD_GROUP;
      job.mask = flood_mask(cfg, frame.ingress_port, NUM_PORTS);
    end else begin
      job.final_res = 1'b0;
      job.mask = flood_mask(cfg, frame.ingress_port, NUM_PORTS);
    end
  end
endmodule

[rtl/core/bfwd_queue.sv]
module bfwd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  bfwd_pkg::job_t push_job,
  input  logic           pop,
  output logic           full,
  output logic           job_valid,
  output bfwd_pkg::job_t job
);
  import bfwd_pkg::*;

  job_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full = count == 2'd2;
  assign job_valid = count != 2'd0;
  assign job = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

[rtl/core/bfwd_back.sv]
module bfwd_back #(
  parameter int NUM_PORTS = 8,
  parameter int ENTRIES_PER_PORT = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  bfwd_pkg::cfg_t  cfg,
  input  logic            job_valid,
  input  bfwd_pkg::job_t  job,
  output logic            pop,
  output logic            clearing,
  bfwd_result_if.source   result
);
  import bfwd_pkg::*;

  localparam int NB = (NUM_PORTS < 8) ? NUM_PORTS : 8;
  localparam int IW = $clog2(ENTRIES_PER_PORT);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES_PER_PORT - 1);

  back_state_t state, state_next;
  logic [IW-1:0] cnt;
  logic          pv;
  logic [IW-1:0] pidx;
  job_t          cur;
  ent_t          rd [NB];

  logic [NB-1:0]      we;
  logic [IW-1:0]      waddr;
  ent_t               wdata;

  logic [NB-1:0]      dhit;
  logic [IW-1:0]      didx [NB];
  logic [NB-1:0]      dvalid;
  logic [STAMP_W-1:0] dstamp [NB];

  logic          lmatch, lfree, nospace;
  logic [IW-1:0] lslot, fslot;
  logic          learn_ok;
  logic [IW-1:0] slot;

  logic               found, fvalid, inval;
  logic [2:0]         fport;
  logic [IW-1:0]      fidx;
  logic [STAMP_W-1:0] fstamp;
  logic               expired;

  disp_t       r_disp;
  logic [7:0]  r_mask;
  logic        r_cons;
  logic        ovalid;
  logic        load;

  assign learn_ok = lmatch || lfree;
  assign slot = lmatch ? lslot : fslot;
  assign clearing = state == B_CLEAR;
  assign pop = state == B_IDLE && job_valid;
  assign load = state == B_DONE && (!ovalid || result.ready);
  assign expired = ({1'b0, fstamp} + {1'b0, cfg.aging_time}) < {1'b0, cur.now};
  assign result.valid = ovalid;

  for (genvar b = 0; b < NB; b++) begin : g_bank
    ent_t mem [ENTRIES_PER_PORT];
    always_ff @(posedge clk) begin
      if (we[b]) mem[waddr] <= wdata;
      rd[b] <= mem[cnt];
    end
  end

  always_comb begin
    we = '0;
    waddr = cnt;
    wdata = '0;
    unique case (state)
      B_CLEAR: we = '1;
      B_LEARN: begin
        waddr = slot;
        wdata = '{used: 1'b1, valid: 1'b1, mac: cur.src, stamp: cur.now};
        for (int b = 0; b < NB; b++) we[b] = learn_ok && 3'(b) == cur.port;
      end
      B_INVAL: begin
        waddr = fidx;
        wdata = '{used: 1'b1, valid: 1'b0, mac: cur.dst, stamp: fstamp};
        for (int b = 0; b < NB; b++) we[b] = inval && 3'(b) == fport;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (cnt == LAST) state_next = B_IDLE;
      B_IDLE: begin
        if (job_valid) state_next = job.final_res ? B_DONE : B_SCAN;
      end
      B_SCAN: if (cnt == LAST) state_next = B_SCAN_LAST;
      B_SCAN_LAST: state_next = B_LEARN;
      B_LEARN: state_next = B_PICK;
      B_PICK: state_next = B_DECIDE;
      B_DECIDE: state_next = B_INVAL;
      B_INVAL: state_next = B_DONE;
      B_DONE: if (load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      pv <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      pv <= state == B_SCAN;
      if (state == B_CLEAR || state == B_SCAN) cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      if (load) ovalid <= 1'b1;
      else if (result.ready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pidx <= cnt;
    if (pop) begin
      cur <= job;
      dhit <= '0;
      lmatch <= 1'b0;
      lfree <= 1'b0;
      nospace <= 1'b0;
      r_disp <= job.disp;
      r_mask <= job.mask;
      r_cons <= job.consumed;
    end
    if (pv) begin
      for (int b = 0; b < NB; b++) begin
        if (!dhit[b] && rd[b].used && rd[b].mac == cur.dst) begin
          dhit[b] <= 1'b1;
          didx[b] <= pidx;
          dvalid[b] <= rd[b].valid;
          dstamp[b] <= rd[b].stamp;
        end
        if (3'(b) == cur.port) begin
          if (!lmatch && rd[b].used && rd[b].mac == cur.src) begin
            lmatch <= 1'b1;
            lslot <= pidx;
          end
          if (!lfree && !rd[b].used) begin
            lfree <= 1'b1;
            fslot <= pidx;
          end
        end
      end
    end
    if (state == B_LEARN) begin
      nospace <= !learn_ok;
      if (learn_ok && cur.src == cur.dst) begin
        for (int b = 0; b < NB; b++) begin
          if (3'(b) == cur.port) begin
            dhit[b] <= 1'b1;
            didx[b] <= slot;
            dvalid[b] <= 1'b1;
            dstamp[b] <= cur.now;
          end
        end
      end
    end
    if (state == B_PICK) begin
      found <= 1'b0;
      for (int b = NB - 1; b >= 1; b--) begin
        if (dhit[b] && 4'(b) < port_limit(cfg.ports_in_use, NUM_PORTS)) begin
          found <= 1'b1;
          fport <= 3'(b);
          fidx <= didx[b];
          fvalid <= dvalid[b];
          fstamp <= dstamp[b];
        end
      end
    end
    if (state == B_DECIDE) begin
      inval <= 1'b0;
      r_cons <= 1'b0;
      r_mask <= '0;
      if (!found || !fvalid) begin
        r_disp <= DISP_FLOOD_UNK;
        r_mask <= cur.mask;
      end else if (fport != cur.port &&
                   port_state(cfg.port_states, fport, NUM_PORTS) == ST_FORWARDING) begin
        if (expired) begin
          inval <= 1'b1;
          r_disp <= DISP_FLOOD_AGED;
          r_mask <= cur.mask;
        end else begin
          r_disp <= DISP_FORWARD;
          r_mask <= 8'd1 << fport;
          r_cons <= 1'b1;
        end
      end else if (expired) begin
        inval <= 1'b1;
        r_disp <= DISP_SAME_AGED;
      end else begin
        r_disp <= DISP_SAME_PORT;
      end
    end
    if (load) begin
      result.disposition <= r_disp;
      result.egress_mask <= r_mask;
      result.consumed <= r_cons;
      result.learn_no_space <= nospace;
    end
  end
endmodule
